// ===== src/crank_angle_fire_scheduler_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Crank angle fire scheduler assertion macros
// Shared concurrent assertion forms for the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef CRANK_ANGLE_FIRE_SCHEDULER_UNIT_MACROS_SVH
`define CRANK_ANGLE_FIRE_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, checked outside reset
`define CAFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== src/cafs_pkg.sv =====
// ---------------------------------------------------------------------------
// Crank angle fire scheduler package
// Shared types, register indexes, pin bits and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package cafs_pkg;

    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;
    localparam int TOOTH_W       = 8;
    localparam int PIN_W         = 6;
    localparam int TEETH_TOP_DEF = 60;

    // register indexes, in priority order
    localparam logic [REG_IDX_W-1:0] REG_COIL14_ON  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COIL14_OFF = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INJ14_ON   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INJ14_OFF  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COIL23_ON  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COIL23_OFF = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INJ23_ON   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INJ23_OFF  = 3'd7;

    // output pin bit positions
    localparam int PIN_INJ1   = 0;
    localparam int PIN_INJ3   = 1;
    localparam int PIN_INJ4   = 2;
    localparam int PIN_INJ2   = 3;
    localparam int PIN_COIL14 = 4;
    localparam int PIN_COIL23 = 5;

    typedef logic [TOOTH_W-1:0] t_tooth;
    typedef t_tooth t_angle_regs [NUM_REGS];

    typedef struct packed {
        t_tooth           tooth_count;
        logic             half_flag;
        logic [PIN_W-1:0] pins;
    } t_sched_state;

    localparam t_angle_regs CFG_RESET = '{
        8'd2, 8'd4, 8'd0, 8'd0, 8'd32, 8'd34, 8'd0, 8'd0
    };

endpackage

`default_nettype wire

// ===== src/cafs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Crank angle fire scheduler angle registers
// Eight tooth-position registers written through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module cafs_cfg_regs
    import cafs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TOOTH_W-1:0]   i_cfg_wdata,
    output t_angle_regs               o_regs
);

    t_angle_regs r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_index] <= i_cfg_wdata;
        end
    end

    assign o_regs = r_regs;

endmodule

`default_nettype wire

// ===== src/cafs_eval.sv =====
// ---------------------------------------------------------------------------
// Crank angle fire scheduler evaluation logic
// Advance the tooth count and apply the first matching angle register.
// ---------------------------------------------------------------------------
`default_nettype none

module cafs_eval
    import cafs_pkg::*;
#(
    parameter int TEETH_TOP = TEETH_TOP_DEF
)
(
    input  wire t_sched_state i_state,
    input  wire logic         i_tooth_edge,
    input  wire t_angle_regs  i_regs,
    output t_sched_state      o_state,
    output logic              o_restart_pwm
);

    localparam t_tooth TopVal = TOOTH_W'(TEETH_TOP);

    t_tooth           pos;
    logic             half;
    logic [PIN_W-1:0] pins;
    logic [PIN_W-1:0] inj14_mask;
    logic [PIN_W-1:0] inj23_mask;

    always_comb begin
        pos  = i_state.tooth_count;
        half = i_state.half_flag;
        if (i_tooth_edge) begin
            if (i_state.tooth_count >= TopVal) begin
                pos  = '0;
                half = ~i_state.half_flag;
            end else begin
                pos = i_state.tooth_count + TOOTH_W'(1);
            end
        end
    end

    always_comb begin
        inj14_mask = '0;
        inj23_mask = '0;
        if (half) begin
            inj14_mask[PIN_INJ1] = 1'b1;
            inj23_mask[PIN_INJ3] = 1'b1;
        end else begin
            inj14_mask[PIN_INJ4] = 1'b1;
            inj23_mask[PIN_INJ2] = 1'b1;
        end
    end

    always_comb begin
        pins          = i_state.pins;
        o_restart_pwm = 1'b0;
        priority if (pos == i_regs[REG_COIL14_ON]) begin
            pins[PIN_COIL14] = 1'b1;
            o_restart_pwm    = ~half;
        end else if (pos == i_regs[REG_COIL14_OFF]) begin
            pins[PIN_COIL14] = 1'b0;
        end else if (pos == i_regs[REG_INJ14_ON]) begin
            pins = pins | inj14_mask;
        end else if (pos == i_regs[REG_INJ14_OFF]) begin
            pins = pins & ~inj14_mask;
        end else if (pos == i_regs[REG_COIL23_ON]) begin
            pins[PIN_COIL23] = 1'b1;
        end else if (pos == i_regs[REG_COIL23_OFF]) begin
            pins[PIN_COIL23] = 1'b0;
        end else if (pos == i_regs[REG_INJ23_ON]) begin
            pins = pins | inj23_mask;
        end else if (pos == i_regs[REG_INJ23_OFF]) begin
            pins = pins & ~inj23_mask;
        end else begin
            pins = i_state.pins;
        end
    end

    assign o_state.tooth_count = pos;
    assign o_state.half_flag   = half;
    assign o_state.pins        = pins;

endmodule

`default_nettype wire

// ===== src/crank_angle_fire_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// Crank angle fire scheduler
// Each input transfer carries tooth_edge: 1 advances the crank tooth count
// (wrapping to 0 past TEETH_TOP and toggling the cycle half), 0 compares
// again at the same position. Every input transfer yields exactly one output
// transfer with the pin word, the PWM restart pulse, the tooth position and
// the cycle half after that item.
// Each item passes through an input register then the result register, with
// the compare logic between them. One item per cycle is sustained; the input
// register keeps taking transfers while a result waits, and o_in_ready drops
// only when both registers are full and the receiver stalls.
// Angle registers are written through i_cfg_we/i_cfg_index/i_cfg_wdata by the
// user only while no item is in flight; the block does not enforce this.
// Synchronous reset clears the count, the half flag, the pins and both valid
// flags, and loads the default angle registers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "crank_angle_fire_scheduler_unit_macros.svh"

module crank_angle_fire_scheduler_unit
    import cafs_pkg::*;
#(
    parameter int TEETH_TOP = TEETH_TOP_DEF
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_tooth_edge,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PIN_W-1:0]          o_port_pins,
    output logic                      o_restart_pwm,
    output logic [TOOTH_W-1:0]        o_tooth_position,
    output logic                      o_cycle_half,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TOOTH_W-1:0]   i_cfg_wdata
);

    localparam t_tooth TopVal = TOOTH_W'(TEETH_TOP);

    t_angle_regs  regs;
    t_sched_state r_state;
    t_sched_state n_state;
    logic         n_restart;
    logic         r_in_valid;
    logic         r_in_edge;
    logic         r_out_valid;
    logic         r_restart;
    logic         advance;

    cafs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_regs      (regs)
    );

    cafs_eval #(
        .TEETH_TOP (TEETH_TOP)
    ) u_eval (
        .i_state       (r_state),
        .i_tooth_edge  (r_in_edge),
        .i_regs        (regs),
        .o_state       (n_state),
        .o_restart_pwm (n_restart)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_edge <= i_tooth_edge;
        end
    end

    // scheduler state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_restart   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state   <= n_state;
                r_restart <= n_restart;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_port_pins      = r_state.pins;
    assign o_restart_pwm    = r_restart;
    assign o_tooth_position = r_state.tooth_count;
    assign o_cycle_half     = r_state.half_flag;

    `CAFS_ASSERT_NOW(a_restart_coil, i_clk, i_rst_n,
        r_out_valid && r_restart, r_state.pins[PIN_COIL14] && !r_state.half_flag)
    `CAFS_ASSERT_NOW(a_tooth_range, i_clk, i_rst_n,
        r_out_valid, r_state.tooth_count <= TopVal)
    `CAFS_ASSERT_NEXT(a_stall_holds_state, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, $stable(r_state) && $stable(r_restart))

endmodule

`default_nettype wire
